// ===== hdl/els_pkg.sv =====
// ----------------------------------------------------------------------------
// els_pkg - shared types and constants of the look-scheduling elevator
// Floor and table sizes, request progress codes, the carry record that runs
// down the cell chain and the command word broadcast to the cells.
// ----------------------------------------------------------------------------
package els_pkg;

  localparam int FLOORS       = 10;
  localparam int MAX_REQUESTS = 16;

  localparam int FLOOR_W = 4;
  localparam int TIME_W  = 16;
  localparam int RIDER_W = 3;
  localparam int IDX_W   = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int CNT_W   = $clog2(MAX_REQUESTS + 1);

  localparam logic [FLOOR_W-1:0] FLOOR_RESET = FLOOR_W'(1);
  localparam logic [RIDER_W-1:0] CAP_RESET   = RIDER_W'(4);
  localparam logic [RIDER_W-1:0] RIDER_MAX   = {RIDER_W{1'b1}};
  localparam logic [TIME_W-1:0]  TIME_MAX    = {TIME_W{1'b1}};

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_STEP = 1'b1;

  typedef enum logic [1:0] {
    PROG_WAIT      = 2'd0,
    PROG_CARRIED   = 2'd1,
    PROG_DELIVERED = 2'd2
  } prog_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EVAL
  } state_e;

  // best pickup and best drop-off found so far along the chain
  typedef struct packed {
    logic               fx;
    logic [FLOOR_W-1:0] x;
    logic [IDX_W-1:0]   j;
    logic               fy;
    logic [FLOOR_W-1:0] y;
    logic [IDX_W-1:0]   k;
  } carry_t;

  // cabin position and direction seen by every cell
  typedef struct packed {
    logic [FLOOR_W-1:0] cab;
    logic               up;
  } look_t;

  typedef struct packed {
    logic               ld_en;
    logic [IDX_W-1:0]   ld_idx;
    logic [FLOOR_W-1:0] ld_pick;
    logic [FLOOR_W-1:0] ld_drop;
    logic               pick_en;
    logic [IDX_W-1:0]   pick_idx;
    logic               drop_en;
    logic [IDX_W-1:0]   drop_idx;
  } cmd_t;

endpackage

// ===== hdl/els_cell.sv =====
// ----------------------------------------------------------------------------
// els_cell - one request slot of the scan chain
// Holds one request and its progress, folds it into the carry record coming
// from the previous cell and registers the result for the next one.
// ----------------------------------------------------------------------------
module els_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [els_pkg::IDX_W-1:0]     cell_idx_i,
  input  els_pkg::look_t                look_i,
  input  els_pkg::cmd_t                 cmd_i,
  input  els_pkg::carry_t               carry_i,
  output els_pkg::carry_t               carry_o
);
  import els_pkg::*;

  logic               valid_q;
  prog_e              prog_q;
  logic [FLOOR_W-1:0] pick_q;
  logic [FLOOR_W-1:0] drop_q;
  carry_t             carry_q;
  carry_t             carry_d;
  logic               take_x;
  logic               take_y;

  always_comb begin
    take_x = 1'b0;
    take_y = 1'b0;
    if (valid_q && prog_q == PROG_WAIT) begin
      if (look_i.up) begin
        take_x = (pick_q >= look_i.cab) && (!carry_i.fx || pick_q < carry_i.x);
      end else begin
        take_x = (pick_q <= look_i.cab) && (!carry_i.fx || pick_q > carry_i.x);
      end
    end
    if (valid_q && prog_q == PROG_CARRIED) begin
      if (look_i.up) begin
        take_y = (drop_q >= look_i.cab) && (!carry_i.fy || drop_q < carry_i.y);
      end else begin
        take_y = (drop_q <= look_i.cab) && (!carry_i.fy || drop_q > carry_i.y);
      end
    end
    carry_d = carry_i;
    if (take_x) begin
      carry_d.fx = 1'b1;
      carry_d.x  = pick_q;
      carry_d.j  = cell_idx_i;
    end
    if (take_y) begin
      carry_d.fy = 1'b1;
      carry_d.y  = drop_q;
      carry_d.k  = cell_idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      prog_q  <= PROG_WAIT;
      carry_q <= '0;
    end else begin
      carry_q <= carry_d;
      if (cmd_i.ld_en && cmd_i.ld_idx == cell_idx_i) begin
        valid_q <= 1'b1;
        prog_q  <= PROG_WAIT;
      end else if (cmd_i.drop_en && cmd_i.drop_idx == cell_idx_i) begin
        prog_q <= PROG_DELIVERED;
      end else if (cmd_i.pick_en && cmd_i.pick_idx == cell_idx_i) begin
        prog_q <= PROG_CARRIED;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_en && cmd_i.ld_idx == cell_idx_i) begin
      pick_q <= cmd_i.ld_pick;
      drop_q <= cmd_i.ld_drop;
    end
  end

  assign carry_o = carry_q;

endmodule

// ===== hdl/els_chain.sv =====
// ----------------------------------------------------------------------------
// els_chain - row of request cells
// The empty carry enters the first cell; each cell registers the carry for
// the next, and the last cell presents the nearest pickup and drop-off ahead of the cabin.
// ----------------------------------------------------------------------------
module els_chain (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  els_pkg::look_t  look_i,
  input  els_pkg::cmd_t   cmd_i,
  output els_pkg::carry_t best_o
);
  import els_pkg::*;

  carry_t link [MAX_REQUESTS];

  for (genvar i = 0; i < MAX_REQUESTS; i++) begin : g_cell
    carry_t cin;
    if (i == 0) begin : g_head
      assign cin = '0;
    end else begin : g_link
      assign cin = link[i-1];
    end
    els_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (IDX_W'(i)),
      .look_i     (look_i),
      .cmd_i      (cmd_i),
      .carry_i    (cin),
      .carry_o    (link[i])
    );
  end

  assign best_o = link[MAX_REQUESTS-1];

endmodule

// ===== hdl/elevator_look_scheduler.sv =====
// ----------------------------------------------------------------------------
// elevator_look_scheduler - elevator controller with look scheduling
// Stores requests in a chain of cells, scans it for the nearest stop ahead
// of the cabin and moves the cabin one stop per step command.
// ----------------------------------------------------------------------------
//  channel   signals                                        direction
//  command   start_i, busy_o, action_i, start_floor_i,       in
//            dest_floor_i
//  result    result_valid_o, rejected_o, floor_o,            out
//            elapsed_o, riders_o, finished_o
//  config    capacity_we_i, capacity_i                       in
//
//  a load, or a step once finished, gives its result in the cycle after the beat
//  a step scans the cell chain, and scans it once more when
//  the direction turns: one pass of the carry down the cell chain per scan
//  busy_o stays high until the result strobe; the receiver cannot stall
//  reset clears the table, puts the cabin on floor 1 going up, capacity 4
// ----------------------------------------------------------------------------
module elevator_look_scheduler (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          action_i,
  input  logic [els_pkg::FLOOR_W-1:0]   start_floor_i,
  input  logic [els_pkg::FLOOR_W-1:0]   dest_floor_i,
  input  logic                          capacity_we_i,
  input  logic [els_pkg::RIDER_W-1:0]   capacity_i,
  output logic                          result_valid_o,
  output logic                          rejected_o,
  output logic [els_pkg::FLOOR_W-1:0]   floor_o,
  output logic [els_pkg::TIME_W-1:0]    elapsed_o,
  output logic [els_pkg::RIDER_W-1:0]   riders_o,
  output logic                          finished_o
);
  import els_pkg::*;

  state_e             state_q, state_d;
  logic [IDX_W-1:0]   cnt_q, cnt_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [FLOOR_W-1:0] cab_q, cab_d;
  logic [TIME_W-1:0]  elapsed_q, elapsed_d;
  logic [RIDER_W-1:0] riders_q, riders_d;
  logic [RIDER_W-1:0] cap_q;
  logic               up_q, up_d;
  logic               mayrev_q, mayrev_d;
  logic               done_q, done_d;
  logic               tried_q, tried_d;
  logic               rej_q, rej_d;
  logic               valid_q, valid_d;

  look_t              look;
  cmd_t               cmd;
  carry_t             best;

  logic               full;
  logic               rescan;
  logic               load_ok;
  logic [FLOOR_W-1:0] dest;
  logic [FLOOR_W-1:0] hops;
  logic [TIME_W:0]    time_sum;

  assign look.cab = cab_q;
  assign look.up  = up_q;

  els_chain u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .look_i (look),
    .cmd_i  (cmd),
    .best_o (best)
  );

  assign full = riders_q >= cap_q;
  // nothing ahead but a turn is still allowed
  assign rescan = full ? (!best.fy && !tried_q)
                       : (!best.fx && !best.fy && mayrev_q);

  assign load_ok = start_floor_i >= FLOOR_W'(1) && start_floor_i <= FLOOR_W'(FLOORS) &&
                   dest_floor_i >= FLOOR_W'(1) && dest_floor_i <= FLOOR_W'(FLOORS) &&
                   start_floor_i != dest_floor_i &&
                   count_q < CNT_W'(MAX_REQUESTS);

  // unless the cabin is full, pickup wins when it lies strictly nearer, or equal (served as a pair)
  logic take_pick;
  assign take_pick = !full && best.fx &&
                     (!best.fy || (up_q ? best.x <= best.y : best.x >= best.y));

  assign dest     = take_pick ? best.x : best.y;
  assign hops     = (dest > cab_q) ? dest - cab_q : cab_q - dest;
  assign time_sum = {1'b0, elapsed_q} + (TIME_W+1)'(hops);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i && action_i == ACT_STEP && !done_q) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (cnt_q == IDX_W'(MAX_REQUESTS - 1)) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        state_d = rescan ? ST_SCAN : ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cnt_d     = cnt_q;
    count_d   = count_q;
    cab_d     = cab_q;
    elapsed_d = elapsed_q;
    riders_d  = riders_q;
    up_d      = up_q;
    mayrev_d  = mayrev_q;
    done_d    = done_q;
    tried_d   = tried_q;
    rej_d     = rej_q;
    valid_d   = 1'b0;
    cmd       = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          tried_d = 1'b0;
          cnt_d   = '0;
          if (action_i == ACT_LOAD) begin
            valid_d = 1'b1;
            rej_d   = !load_ok;
            if (load_ok) begin
              cmd.ld_en   = 1'b1;
              cmd.ld_idx  = count_q[IDX_W-1:0];
              cmd.ld_pick = start_floor_i;
              cmd.ld_drop = dest_floor_i;
              count_d     = count_q + CNT_W'(1);
              done_d      = 1'b0;
            end
          end else begin
            rej_d   = 1'b0;
            valid_d = done_q;
          end
        end
      end
      ST_SCAN: begin
        cnt_d = cnt_q + IDX_W'(1);
      end
      ST_EVAL: begin
        cnt_d = '0;
        if (rescan) begin
          up_d = !up_q;
          if (full) begin
            tried_d = 1'b1;
          end else begin
            mayrev_d = 1'b0;
          end
        end else if (full ? !best.fy : (!best.fx && !best.fy)) begin
          done_d  = 1'b1;
          valid_d = 1'b1;
        end else begin
          valid_d   = 1'b1;
          cab_d     = dest;
          elapsed_d = time_sum[TIME_W] ? TIME_MAX : time_sum[TIME_W-1:0];
          if (!full) mayrev_d = 1'b1;
          if (take_pick) begin
            cmd.pick_en  = 1'b1;
            cmd.pick_idx = best.j;
            if (best.fy && best.x == best.y) begin
              // pickup and drop-off on one floor
              cmd.drop_en  = 1'b1;
              cmd.drop_idx = best.k;
            end else if (riders_q < RIDER_MAX) begin
              riders_d = riders_q + RIDER_W'(1);
            end
          end else begin
            cmd.drop_en  = 1'b1;
            cmd.drop_idx = best.k;
            if (riders_q != '0) riders_d = riders_q - RIDER_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      count_q   <= '0;
      cab_q     <= FLOOR_RESET;
      elapsed_q <= '0;
      riders_q  <= '0;
      cap_q     <= CAP_RESET;
      up_q      <= 1'b1;
      mayrev_q  <= 1'b1;
      done_q    <= 1'b0;
      tried_q   <= 1'b0;
      rej_q     <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      count_q   <= count_d;
      cab_q     <= cab_d;
      elapsed_q <= elapsed_d;
      riders_q  <= riders_d;
      up_q      <= up_d;
      mayrev_q  <= mayrev_d;
      done_q    <= done_d;
      tried_q   <= tried_d;
      rej_q     <= rej_d;
      valid_q   <= valid_d;
      if (capacity_we_i) cap_q <= capacity_i;
    end
  end

  assign busy_o         = state_q != ST_IDLE;
  assign result_valid_o = valid_q;
  assign rejected_o     = rej_q;
  assign floor_o        = cab_q;
  assign elapsed_o      = elapsed_q;
  assign riders_o       = riders_q;
  assign finished_o     = done_q;

`ifndef SYNTHESIS
  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy_o)
    else $error("result beat while still busy");

  a_reject_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rejected_o |-> !$past(busy_o))
    else $error("reject flag raised by a step");

  a_load_no_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && action_i == ACT_LOAD) |=> $stable(floor_o) && $stable(elapsed_o))
    else $error("load moved the cabin");

  a_time_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(elapsed_o < $past(elapsed_o)))
    else $error("elapsed floors went down");

  a_scan_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |=> $stable(floor_o) && $stable(riders_o))
    else $error("cabin state changed during a scan");
`endif

endmodule
